FILE: hw/rtl/sks_pkg.sv
// shared types and constants for the sorted key set
package sks_pkg;

  localparam int DEF_CAPACITY  = 16;
  localparam int DEF_KEY_WIDTH = 32;
  localparam int FIELD_W       = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [FIELD_W-1:0]   position;
    logic [FIELD_W-1:0]   entry_count;
  } rsp_t;

  // commands broadcast to every cell of the chain
  typedef struct packed {
    logic cmp;   // latch compare flags against the broadcast key
    logic ins;   // open a slot at the boundary and write the key
    logic del;   // close the slot at the boundary
  } cell_ctl_t;

endpackage

FILE: hw/rtl/sks_cell.sv
// one storage cell of the sorted key chain
module sks_cell #(
  parameter int KEY_WIDTH = sks_pkg::DEF_KEY_WIDTH
) (
  input  logic                        clk,
  input  sks_pkg::cell_ctl_t          ctl,
  input  logic signed [KEY_WIDTH-1:0] bkey,
  input  logic                        below_count,
  input  logic signed [KEY_WIDTH-1:0] left_key,
  input  logic signed [KEY_WIDTH-1:0] right_key,
  input  logic                        left_lt,
  output logic signed [KEY_WIDTH-1:0] key,
  output logic                        lt,
  output logic                        eq
);
  import sks_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt <= below_count && (key < bkey);
      eq <= below_count && (key == bkey);
    end
    // cells holding smaller keys never move
    if (ctl.ins && !lt) begin
      key <= left_lt ? bkey : left_key;
    end else if (ctl.del && !lt) begin
      key <= right_key;
    end
  end

endmodule

FILE: hw/rtl/sorted_key_set.sv
// top level of the sorted key set: chain of compare-and-shift cells
//
// usage:
//   req channel carries one item {op, key}; rsp channel returns one item
//   {status, position, entry_count} per request. both use valid / stall,
//   an item moves on a rising edge with valid high and stall low.
//   every cell compares the broadcast key at once, so the lower bound is
//   found from the row of "less than" flags with no scan.
// timing:
//   an item is taken on an accepting edge (cells latch their compare flags)
//   and executed in the EXEC state (status built, chain shifts by one place
//   on insert or delete, result registered) once the output register is free.
//   no new item is taken until the previous one has executed.
//   req_stall is high during the execute cycle.
// reset:
//   rst (synchronous, active high) empties the set and drops rsp_valid.
//   key storage is not cleared; cells at or above the count are masked from every compare.
// stall:
//   a result waits in the output register while rsp_stall is high; the next
//   item may still be accepted, and its execute cycle holds until the
//   output register is free.
module sorted_key_set #(
  parameter int CAPACITY  = sks_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = sks_pkg::DEF_KEY_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sks_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sks_pkg::rsp_t rsp
);
  import sks_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_t                      state, state_next;
  op_t                         op_q;
  logic signed [KEY_WIDTH-1:0] bkey;
  logic [CNT_W-1:0]            count, count_next;

  logic signed [KEY_WIDTH-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]         cell_lt, cell_eq, left_lt, boundary;
  cell_ctl_t                   ctl;

  logic                        req_take, out_free, advance;
  logic                        found, full;
  logic [IDX_W-1:0]            pos_enc;
  logic [CNT_W-1:0]            pos;
  status_t                     status;

  // ---- handshake ----------------------------------------------------------
  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign advance   = (state == S_EXEC) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_take) state_next = S_EXEC;
      S_EXEC: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // key is sign-extended or truncated to the store's width
  always_ff @(posedge clk) begin
    if (req_take) begin
      op_q <= req.op;
      bkey <= KEY_WIDTH'(req.key);
    end
  end

  // ---- cell chain ---------------------------------------------------------
  assign full = (count == CNT_W'(CAPACITY));

  always_comb begin
    ctl.cmp = req_take;
    ctl.ins = advance && (op_q == OP_INSERT) && !found && !full;
    ctl.del = advance && (op_q == OP_DELETE) && found;
  end

  // compare flags are latched from the incoming key in the accept cycle
  logic signed [KEY_WIDTH-1:0] cmp_key;
  assign cmp_key = req_take ? KEY_WIDTH'(req.key) : bkey;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_WIDTH-1:0] lkey, rkey;
    if (i == 0) begin : g_first
      assign lkey       = cell_key[0];
      assign left_lt[0] = 1'b1;
    end else begin : g_rest
      assign lkey       = cell_key[i-1];
      assign left_lt[i] = cell_lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rkey = cell_key[i];
    end else begin : g_inner
      assign rkey = cell_key[i+1];
    end

    sks_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .bkey       (cmp_key),
      .below_count(CNT_W'(i) < count),
      .left_key   (lkey),
      .right_key  (rkey),
      .left_lt    (left_lt[i]),
      .key        (cell_key[i]),
      .lt         (cell_lt[i]),
      .eq         (cell_eq[i])
    );
  end

  // lt flags form a thermometer; the boundary cell is where it ends
  assign boundary = left_lt & ~cell_lt;
  assign found    = |cell_eq;

  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pos_enc = pos_enc | (boundary[i] ? IDX_W'(i) : IDX_W'(0));
    end
  end

  // a full set with every held key smaller: position is the capacity itself
  assign pos = cell_lt[CAPACITY-1] ? CNT_W'(CAPACITY) : CNT_W'(pos_enc);

  // ---- execute ------------------------------------------------------------
  always_comb begin
    status     = ST_OK;
    count_next = count;
    case (op_q)
      OP_INSERT: begin
        if (found) begin
          status = ST_PRESENT;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (found) begin
          count_next = count - CNT_W'(1);
        end else begin
          status = ST_ABSENT;
        end
      end
      OP_LOOKUP: status = found ? ST_OK : ST_ABSENT;
      default:   count_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (advance) begin
      count <= count_next;
    end
  end

  // ---- output register ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.status      <= status;
      rsp.position    <= (op_q == OP_CLEAR) ? '0 : FIELD_W'(pos);
      rsp.entry_count <= FIELD_W'(count_next);
    end
  end

endmodule
